FILE: src/cpmc_pkg.sv
// Package: shared types, constants and sequencer states of the cascaded PID controller
`timescale 1ns / 1ps
package cpmc_pkg;

	// Default parameter values
	localparam int INT_LIMIT_D      = 1048576;
	localparam int OUT_LIMIT_D      = 536870912;
	localparam int INT_STEP_SHIFT_D = 4;
	localparam int POS_ERR_LIMIT_D  = 65536;
	localparam int STALL_DELAY_D    = 500;

	// Fixed thresholds and filter weights
	localparam logic signed [16:0] ALPHA_NEW  = 17'sd25166;
	localparam logic signed [16:0] ALPHA_OLD  = 17'sd40305;
	localparam logic [31:0]        ARRIVE_THR = 32'd32768;
	localparam logic [31:0]        STUCK_THR  = 32'd19661;
	localparam logic [31:0]        NEAR_THR   = 32'd655360;
	localparam logic signed [31:0] RESUME_THR = 32'sd98304;

	// Mode codes
	localparam logic [2:0] MODE_VEL   = 3'd0;
	localparam logic [2:0] MODE_POS   = 3'd1;
	localparam logic [2:0] MODE_MULTI = 3'd2;
	localparam logic [2:0] MODE_CUR   = 3'd3;
	localparam logic [2:0] MODE_STALL = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_TARGET   = 3'd1;
	localparam logic [2:0] REG_OUTER_KP = 3'd2;
	localparam logic [2:0] REG_OUTER_KI = 3'd3;
	localparam logic [2:0] REG_OUTER_KD = 3'd4;
	localparam logic [2:0] REG_INNER_KP = 3'd5;
	localparam logic [2:0] REG_INNER_KI = 3'd6;
	localparam logic [2:0] REG_INNER_KD = 3'd7;

	typedef struct packed {
		logic signed [31:0] measured_value;
		logic signed [31:0] measured_velocity;
		logic [15:0]        ticks_since_start;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] drive_out;
		logic               arrived_event;
		logic               stuck_event;
		logic               resume_event;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DERIV_A,
		ST_DERIV_B,
		ST_INTEG,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_SUM,
		ST_NEXT,
		ST_DRIVE,
		ST_OUT
	} state_t;

	// Multiplier operation request
	typedef struct packed {
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mul_req_t;

	// Sign-aware saturation of a wide value to +-lim (full 32-bit range when lim is its maximum)
	function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
		input logic signed [33:0] lim);
		logic signed [33:0] r;
		logic signed [33:0] lo;
		lo = (lim == 34'sd2147483647) ? -lim - 34'sd1 : -lim;
		r = v;
		if (v > lim) r = lim;
		else if (v < lo) r = lo;
		return r;
	endfunction

	// Same saturation for the 50-bit output sum
	function automatic logic signed [49:0] clamp50(input logic signed [49:0] v,
		input logic signed [49:0] lim);
		logic signed [49:0] r;
		logic signed [49:0] lo;
		lo = (lim == 50'sd2147483647) ? -lim - 50'sd1 : -lim;
		r = v;
		if (v > lim) r = lim;
		else if (v < lo) r = lo;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > 34'sh07FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -34'sh080000000) r = 32'sh80000000;
		return r;
	endfunction

endpackage

FILE: src/cpmc_mul.sv
// Module: shared registered signed 33x33 multiplier
`timescale 1ns / 1ps
module cpmc_mul (
	input  logic                     clk,
	input  cpmc_pkg::mul_req_t       req,
	output logic signed [65:0]       prod_q
);

	// One product per cycle, registered before any further use
	always_ff @(posedge clk) begin
		prod_q <= req.a * req.b;
	end

endmodule

FILE: src/cpmc_seq.sv
// Module: sequencer running the outer and inner PID passes on the shared multiplier
`timescale 1ns / 1ps
module cpmc_seq #(
	parameter int INT_LIMIT      = cpmc_pkg::INT_LIMIT_D,
	parameter int OUT_LIMIT      = cpmc_pkg::OUT_LIMIT_D,
	parameter int INT_STEP_SHIFT = cpmc_pkg::INT_STEP_SHIFT_D,
	parameter int POS_ERR_LIMIT  = cpmc_pkg::POS_ERR_LIMIT_D,
	parameter int STALL_DELAY    = cpmc_pkg::STALL_DELAY_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cpmc_pkg::in_item_t    item,
	input  logic                  cfg_we,
	input  cpmc_pkg::cfg_wr_t     cfg,
	output logic                  busy,
	output logic                  done,
	output cpmc_pkg::out_item_t   result,
	input  logic                  result_taken
);

	localparam logic signed [33:0] INT_LIM_S = 34'(INT_LIMIT);
	localparam logic signed [49:0] OUT_LIM_S = 50'(OUT_LIMIT);
	localparam logic signed [33:0] POS_LIM_S = 34'(POS_ERR_LIMIT);

	cpmc_pkg::state_t state_q, state_d;

	// Configuration registers
	logic [2:0]         mode_q;
	logic signed [31:0] target_q;
	logic signed [31:0] okp_q, oki_q, okd_q, ikp_q, iki_q, ikd_q;

	// Loop state
	logic signed [31:0] o_perr_q, o_pder_q, o_int_q;
	logic signed [31:0] i_perr_q, i_pder_q, i_int_q;
	logic               arrived_q, stuck_q;

	// Working registers
	cpmc_pkg::in_item_t item_q;
	logic               inner_q;
	logic signed [31:0] err_q, der_q, int_q;
	logic signed [65:0] acc_q;
	logic signed [49:0] sum_q;
	logic               ev_arr_q, ev_stk_q, ev_res_q;
	cpmc_pkg::out_item_t res_q;

	cpmc_pkg::mul_req_t req;
	logic signed [65:0] prod;

	cpmc_mul u_mul (.clk(clk), .req(req), .prod_q(prod));

	// Active loop selection
	logic signed [31:0] perr, pder, integ, kp, ki, kd;
	always_comb begin
		perr  = inner_q ? i_perr_q : o_perr_q;
		pder  = inner_q ? i_pder_q : o_pder_q;
		integ = inner_q ? i_int_q  : o_int_q;
		kp    = inner_q ? ikp_q : okp_q;
		ki    = inner_q ? iki_q : oki_q;
		kd    = inner_q ? ikd_q : okd_q;
	end

	// Multiplier operand selection
	always_comb begin
		req.a = '0;
		req.b = '0;
		case (state_q)
			cpmc_pkg::ST_DERIV_A: begin
				req.a = 33'(err_q) - 33'(perr);
				req.b = 33'(cpmc_pkg::ALPHA_NEW);
			end
			cpmc_pkg::ST_DERIV_B: begin
				req.a = 33'(pder);
				req.b = 33'(cpmc_pkg::ALPHA_OLD);
			end
			cpmc_pkg::ST_MUL_P: begin
				req.a = 33'(err_q);
				req.b = 33'(kp);
			end
			cpmc_pkg::ST_MUL_D: begin
				req.a = 33'(der_q);
				req.b = 33'(kd);
			end
			cpmc_pkg::ST_MUL_I: begin
				req.a = 33'(int_q);
				req.b = 33'(ki);
			end
			default: begin
				req.a = '0;
				req.b = '0;
			end
		endcase
	end

	// Error and event terms
	logic signed [33:0] raw_err, abs_err, abs_vel;
	logic signed [31:0] vel;
	logic               stk_now, res_now, arr_now;
	logic               stuck_after;
	always_comb begin
		vel     = item_q.measured_velocity;
		raw_err = 34'(target_q) - 34'(item_q.measured_value);
		abs_err = err_q[31] ? -34'(err_q) : 34'(err_q);
		abs_vel = vel[31] ? -34'(vel) : 34'(vel);
		stk_now = (mode_q == cpmc_pkg::MODE_STALL) && (abs_vel < 34'(cpmc_pkg::STUCK_THR))
			&& !stuck_q && !arrived_q && (item_q.ticks_since_start >= 16'(STALL_DELAY))
			&& (abs_err >= 34'(cpmc_pkg::NEAR_THR));
		stuck_after = stuck_q || stk_now;
		res_now = (mode_q == cpmc_pkg::MODE_STALL) && stuck_after
			&& ((vel > cpmc_pkg::RESUME_THR && err_q > 0)
			|| (vel < -cpmc_pkg::RESUME_THR && err_q < 0));
		arr_now = (mode_q == cpmc_pkg::MODE_MULTI || mode_q == cpmc_pkg::MODE_STALL)
			&& (abs_err < 34'(cpmc_pkg::ARRIVE_THR)) && !arrived_q;
	end

	// Derivative, integral and output arithmetic
	logic signed [65:0] der_sum;
	logic signed [33:0] der_sh, new_int, drv_q16;
	logic signed [49:0] sum_now, sum_sat;
	logic signed [33:0] drive_i;
	always_comb begin
		der_sum = acc_q + prod;
		der_sh  = 34'(der_sum >>> 16);
		new_int = cpmc_pkg::clamp34(34'(integ) + 34'(err_q >>> INT_STEP_SHIFT), INT_LIM_S);
		sum_now = sum_q + 50'(prod >>> 16);
		sum_sat = cpmc_pkg::clamp50(sum_q, OUT_LIM_S);
		drv_q16 = (mode_q == cpmc_pkg::MODE_CUR) ? 34'(sum_q) + 34'(target_q) : 34'(sum_q);
		drive_i = drv_q16[33] ? -((-drv_q16) >>> 16) : (drv_q16 >>> 16);
	end

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpmc_pkg::ST_IDLE:    if (start) state_d = cpmc_pkg::ST_ERR;
			cpmc_pkg::ST_ERR:     state_d = (mode_q > cpmc_pkg::MODE_STALL) ?
				cpmc_pkg::ST_DRIVE : cpmc_pkg::ST_DERIV_A;
			cpmc_pkg::ST_DERIV_A: state_d = cpmc_pkg::ST_DERIV_B;
			cpmc_pkg::ST_DERIV_B: state_d = cpmc_pkg::ST_INTEG;
			cpmc_pkg::ST_INTEG:   state_d = cpmc_pkg::ST_MUL_P;
			cpmc_pkg::ST_MUL_P:   state_d = cpmc_pkg::ST_MUL_D;
			cpmc_pkg::ST_MUL_D:   state_d = cpmc_pkg::ST_MUL_I;
			cpmc_pkg::ST_MUL_I:   state_d = cpmc_pkg::ST_SUM;
			cpmc_pkg::ST_SUM:     state_d = cpmc_pkg::ST_NEXT;
			cpmc_pkg::ST_NEXT:    state_d = inner_q ? cpmc_pkg::ST_DRIVE : cpmc_pkg::ST_DERIV_A;
			cpmc_pkg::ST_DRIVE:   state_d = cpmc_pkg::ST_OUT;
			cpmc_pkg::ST_OUT:     if (result_taken) state_d = cpmc_pkg::ST_IDLE;
			default:              state_d = cpmc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cpmc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; target_q <= '0;
			okp_q <= '0; oki_q <= '0; okd_q <= '0;
			ikp_q <= '0; iki_q <= '0; ikd_q <= '0;
			o_perr_q <= '0; o_pder_q <= '0; o_int_q <= '0;
			i_perr_q <= '0; i_pder_q <= '0; i_int_q <= '0;
			arrived_q <= 1'b0; stuck_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg.index)
					cpmc_pkg::REG_MODE:     mode_q <= cfg.data[2:0];
					cpmc_pkg::REG_TARGET: begin
						target_q  <= cfg.data;
						arrived_q <= 1'b0;
						stuck_q   <= 1'b0;
					end
					cpmc_pkg::REG_OUTER_KP: okp_q <= cfg.data;
					cpmc_pkg::REG_OUTER_KI: oki_q <= cfg.data;
					cpmc_pkg::REG_OUTER_KD: okd_q <= cfg.data;
					cpmc_pkg::REG_INNER_KP: ikp_q <= cfg.data;
					cpmc_pkg::REG_INNER_KI: iki_q <= cfg.data;
					cpmc_pkg::REG_INNER_KD: ikd_q <= cfg.data;
					default: ;
				endcase
			end
			// Event flags settle once the outer error is known; resume wins over a new stall
			if (state_q == cpmc_pkg::ST_DERIV_A && !inner_q) begin
				if (stk_now || res_now) stuck_q <= !res_now;
				if (arr_now) arrived_q <= 1'b1;
			end
			// Loop state update
			if (state_q == cpmc_pkg::ST_INTEG) begin
				if (inner_q) begin
					i_perr_q <= err_q; i_pder_q <= cpmc_pkg::sat32(der_sh);
					i_int_q <= new_int[31:0];
				end else begin
					o_perr_q <= err_q; o_pder_q <= cpmc_pkg::sat32(der_sh);
					o_int_q <= new_int[31:0];
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			cpmc_pkg::ST_IDLE: if (start) item_q <= item;
			cpmc_pkg::ST_ERR: begin
				inner_q  <= (mode_q == cpmc_pkg::MODE_VEL) || (mode_q == cpmc_pkg::MODE_CUR);
				ev_arr_q <= 1'b0; ev_stk_q <= 1'b0; ev_res_q <= 1'b0;
				if (mode_q == cpmc_pkg::MODE_POS)
					err_q <= cpmc_pkg::sat32(cpmc_pkg::clamp34(raw_err, POS_LIM_S));
				else
					err_q <= cpmc_pkg::sat32(raw_err);
				sum_q <= '0;
			end
			cpmc_pkg::ST_DERIV_A: begin
				if (!inner_q) begin
					ev_stk_q <= stk_now; ev_res_q <= res_now; ev_arr_q <= arr_now;
				end
				acc_q <= '0;
			end
			cpmc_pkg::ST_DERIV_B: acc_q <= prod;
			cpmc_pkg::ST_INTEG: begin
				der_q <= cpmc_pkg::sat32(der_sh);
				int_q <= new_int[31:0];
				sum_q <= '0;
			end
			cpmc_pkg::ST_MUL_D, cpmc_pkg::ST_MUL_I, cpmc_pkg::ST_SUM: sum_q <= sum_now;
			cpmc_pkg::ST_NEXT: begin
				sum_q <= sum_sat;
				if (!inner_q) begin
					inner_q <= 1'b1;
					err_q   <= cpmc_pkg::sat32(34'(sum_sat)
						- 34'(item_q.measured_velocity));
				end
			end
			cpmc_pkg::ST_DRIVE: begin
				// Event registers stay clear for unused modes
				res_q.arrived_event <= ev_arr_q;
				res_q.stuck_event   <= ev_stk_q;
				res_q.resume_event  <= ev_res_q;
				if (mode_q > cpmc_pkg::MODE_STALL) res_q.drive_out <= '0;
				else if (drive_i > 34'sd32767) res_q.drive_out <= 16'sh7FFF;
				else if (drive_i < -34'sd32768) res_q.drive_out <= 16'sh8000;
				else res_q.drive_out <= drive_i[15:0];
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != cpmc_pkg::ST_IDLE);
	assign done   = (state_q == cpmc_pkg::ST_OUT);
	assign result = res_q;

endmodule

FILE: src/cascaded_pid_motor_controller.sv
// Top level: cascaded position/velocity PID controller with configuration port
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_stall/in_data carry one control tick (measurement, velocity,
//   milliseconds since move start). out_valid/out_stall/out_data carry one drive
//   command with arrival, stall and resume event bits per tick.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the mode, target and gains;
//   write only while no tick is in flight. A target write clears the flags.
// Sequencing:
//   One shared 33x33 multiplier is stepped by a sequencer through each PID
//   pass: inner-only modes run the inner pass, cascaded modes the outer then
//   the inner pass, and unused modes none. One tick is in flight at a time,
//   so in_stall is high from acceptance until the result is taken; the next
//   tick can transfer once the sequencer is back in idle.
// Reset:
//   arst_n clears the mode, target, gains, loop state and event flags.
// Back-pressure:
//   While out_stall is high the result holds on out_data and no new tick
//   is accepted.
module cascaded_pid_motor_controller #(
	parameter int INT_LIMIT      = cpmc_pkg::INT_LIMIT_D,
	parameter int OUT_LIMIT      = cpmc_pkg::OUT_LIMIT_D,
	parameter int INT_STEP_SHIFT = cpmc_pkg::INT_STEP_SHIFT_D,
	parameter int POS_ERR_LIMIT  = cpmc_pkg::POS_ERR_LIMIT_D,
	parameter int STALL_DELAY    = cpmc_pkg::STALL_DELAY_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cpmc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cpmc_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	logic busy, done;
	cpmc_pkg::cfg_wr_t cfg;

	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;
	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign out_valid = done;

	cpmc_seq #(
		.INT_LIMIT(INT_LIMIT), .OUT_LIMIT(OUT_LIMIT), .INT_STEP_SHIFT(INT_STEP_SHIFT),
		.POS_ERR_LIMIT(POS_ERR_LIMIT), .STALL_DELAY(STALL_DELAY)
	) u_seq (
		.clk(clk), .arst_n(arst_n),
		.start(in_valid && !busy), .item(in_data),
		.cfg_we(cfg_valid), .cfg(cfg),
		.busy(busy), .done(done), .result(out_data),
		.result_taken(!out_stall)
	);

`ifndef NO_ASSERTIONS
	// A tick is never accepted while a result waits
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("tick accepted while result pending");
	// A stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// Stall and arrival are never reported on the same tick
	a_events_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.stuck_event && out_data.arrived_event))
		else $error("stall and arrival on one tick");
`endif

endmodule

FILE: sim/testbench.sv
// Testbench for the cascaded PID motor controller: directed and random ticks against a local predictor
`timescale 1ns / 1ps
module testbench;
	import cpmc_pkg::*;

	localparam longint I32MAX = 64'sd2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_MODE;
	logic [31:0] cfg_data = '0;

	cascaded_pid_motor_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of registers and loop state
	logic [2:0] p_mode;
	longint p_target, p_okp, p_oki, p_okd, p_ikp, p_iki, p_ikd;
	longint o_perr, o_pder, o_integ, i_perr, i_pder, i_integ;
	bit p_arrived, p_stuck;

	out_item_t drive_queue[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	function automatic longint clip(longint v, longint lim);
		longint lo;
		lo = (lim == I32MAX) ? -lim - 1 : -lim;
		if (v > lim) return lim;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// One PID pass; loop selects outer (1) or inner (0) state
	function automatic longint pid_pass(longint err, bit outer_loop);
		longint perr, pder, integ, kp, ki, kd, dl, der, sum;
		if (outer_loop) begin
			perr = o_perr; pder = o_pder; integ = o_integ;
			kp = p_okp; ki = p_oki; kd = p_okd;
		end else begin
			perr = i_perr; pder = i_pder; integ = i_integ;
			kp = p_ikp; ki = p_iki; kd = p_ikd;
		end
		dl = err - perr;
		der = clip(asr(dl * 25166 + pder * 40305, 16), I32MAX);
		integ = clip(integ + asr(err, INT_STEP_SHIFT_D), INT_LIMIT_D);
		sum = asr(err * kp, 16) + asr(der * kd, 16) + asr(integ * ki, 16);
		if (outer_loop) begin
			o_perr = err; o_pder = der; o_integ = integ;
		end else begin
			i_perr = err; i_pder = der; i_integ = integ;
		end
		return clip(sum, OUT_LIMIT_D);
	endfunction

	function automatic logic signed [15:0] drive_of(longint q);
		longint i;
		i = q < 0 ? -((-q) >>> 16) : (q >>> 16);
		if (i > 32767) i = 32767;
		if (i < -32768) i = -32768;
		return i[15:0];
	endfunction

	function automatic out_item_t predict_drive(in_item_t it);
		out_item_t r;
		longint meas, vel, err, vt;
		r = '0;
		meas = it.measured_value;
		vel = it.measured_velocity;
		if (p_mode > MODE_STALL) return r;
		err = clip(p_target - meas, I32MAX);
		if (p_mode == MODE_VEL) begin
			r.drive_out = drive_of(pid_pass(err, 0));
		end else if (p_mode == MODE_CUR) begin
			r.drive_out = drive_of(p_target + pid_pass(err, 0));
		end else begin
			if (p_mode == MODE_STALL) begin
				if (mag(vel) < 19661 && !p_stuck && !p_arrived &&
						it.ticks_since_start >= STALL_DELAY_D && mag(err) >= 655360) begin
					p_stuck = 1; r.stuck_event = 1;
				end
				if (p_stuck && ((vel > 98304 && err > 0) || (vel < -98304 && err < 0))) begin
					p_stuck = 0; r.resume_event = 1;
				end
			end
			if (p_mode != MODE_POS && mag(err) < 32768 && !p_arrived) begin
				p_arrived = 1; r.arrived_event = 1;
			end
			if (p_mode == MODE_POS) err = clip(err, POS_ERR_LIMIT_D);
			vt = pid_pass(err, 1);
			r.drive_out = drive_of(pid_pass(clip(vt - vel, I32MAX), 0));
		end
		return r;
	endfunction

	// Write one register through the configuration channel
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:     p_mode = val[2:0];
			REG_TARGET:   begin
				p_target = $signed(val); p_arrived = 0; p_stuck = 0;
			end
			REG_OUTER_KP: p_okp = $signed(val);
			REG_OUTER_KI: p_oki = $signed(val);
			REG_OUTER_KD: p_okd = $signed(val);
			REG_INNER_KP: p_ikp = $signed(val);
			REG_INNER_KI: p_iki = $signed(val);
			default:      p_ikd = $signed(val);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one tick and wait for its transfer
	task automatic send_tick(in_item_t it);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		drive_queue.push_back(predict_drive(it));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait until all results are back, plus the slack of a cascaded pass
	task automatic drain();
		while (drive_queue.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(5, 0))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $urandom_range(131072, 0) - 65536;
		endcase
	endfunction

	function automatic in_item_t rand_tick(longint tgt);
		in_item_t it;
		it.measured_value = ($urandom_range(3, 0) == 0) ? $urandom :
			32'(tgt + $signed($urandom_range(2000000, 0)) - 1000000);
		case ($urandom_range(3, 0))
			0: it.measured_velocity = $urandom;
			1: it.measured_velocity = $urandom_range(40000, 0) - 20000;
			default: it.measured_velocity = $urandom_range(400000, 0) - 200000;
		endcase
		it.ticks_since_start = $urandom_range(1, 0) ? $urandom_range(65535, 0) :
			$urandom_range(700, 300);
		return it;
	endfunction

	// Result checker
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_item = drive_queue.pop_front();
				if (out_data.drive_out !== exp_item.drive_out)
					$display("%0t: drive_out expected %0d actual %0d", $time,
						exp_item.drive_out, out_data.drive_out);
				if (out_data.arrived_event !== exp_item.arrived_event)
					$display("%0t: arrived_event expected %b actual %b", $time,
						exp_item.arrived_event, out_data.arrived_event);
				if (out_data.stuck_event !== exp_item.stuck_event)
					$display("%0t: stuck_event expected %b actual %b", $time,
						exp_item.stuck_event, out_data.stuck_event);
				if (out_data.resume_event !== exp_item.resume_event)
					$display("%0t: resume_event expected %b actual %b", $time,
						exp_item.resume_event, out_data.resume_event);
				if (out_data !== exp_item) errors++;
			end
		end
	end

	// Receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= (recv_idle_pct > 0) && ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	task automatic set_loop(logic [2:0] mode, logic [31:0] tgt);
		write_reg(REG_MODE, mode);
		write_reg(REG_TARGET, tgt);
	endtask

	// Extremes of fields and gains, every mode including unused codes
	task automatic test_directed();
		in_item_t it;
		logic [2:0] m;
		write_reg(REG_OUTER_KP, 32'h00010000);
		write_reg(REG_OUTER_KI, 32'h00008000);
		write_reg(REG_OUTER_KD, 32'h00004000);
		write_reg(REG_INNER_KP, 32'h7FFFFFFF);
		write_reg(REG_INNER_KI, 32'h80000000);
		write_reg(REG_INNER_KD, 32'h00020000);
		for (int k = 0; k < 8; k++) begin
			m = k[2:0];
			set_loop(m, k[0] ? 32'h7FFFFFFF : 32'h80000000);
			it.measured_value = k[0] ? 32'h80000000 : 32'h7FFFFFFF;
			it.measured_velocity = k[1] ? 32'h7FFFFFFF : 32'h80000000;
			it.ticks_since_start = k[2] ? 16'hFFFF : 16'h0000;
			send_tick(it);
			drain();
		end
		// Stall, resume and arrival in position-with-stall mode
		write_reg(REG_INNER_KP, 32'h00010000);
		write_reg(REG_INNER_KI, 32'h00001000);
		set_loop(MODE_STALL, 32'd2000000);
		it = '{32'd0, 32'd0, 16'd499}; send_tick(it);
		it = '{32'd0, 32'd100, 16'd500}; send_tick(it);
		it = '{32'd0, 32'd200000, 16'd600}; send_tick(it);
		it = '{32'd1990000, 32'd0, 16'd700}; send_tick(it);
		it = '{32'd2000000, 32'd0, 16'd800}; send_tick(it);
		drain();
		set_loop(MODE_MULTI, 32'd0);
		it = '{32'd100, 32'hFFFF0000, 16'd1}; send_tick(it);
		it = '{32'd100, 32'hFFFF0000, 16'd2}; send_tick(it);
		drain();
	endtask

	// Random ticks across several register settings
	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_reg(REG_OUTER_KP, rand_gain());
			write_reg(REG_OUTER_KI, rand_gain());
			write_reg(REG_OUTER_KD, rand_gain());
			write_reg(REG_INNER_KP, rand_gain());
			write_reg(REG_INNER_KI, rand_gain());
			write_reg(REG_INNER_KD, rand_gain());
			set_loop(($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5)) :
				3'($urandom_range(4, 0)), $urandom_range(1, 0) ? $urandom :
				$urandom_range(4000000, 0) - 2000000);
			for (int n = 0; n < per_phase; n++) send_tick(rand_tick(p_target));
			drain();
		end
	endtask

	// Long receiver hold-off while ticks keep coming, then a full pause
	task automatic test_backpressure();
		hold_cycles = 300;
		for (int n = 0; n < 10; n++) send_tick(rand_tick(p_target));
		while (drive_queue.size() != 0) @(posedge clk);
		for (int n = 0; n < 10; n++) send_tick(rand_tick(p_target));
		drain();
	endtask

	initial begin
		p_mode = MODE_VEL;
		p_target = 0; p_okp = 0; p_oki = 0; p_okd = 0; p_ikp = 0; p_iki = 0; p_ikd = 0;
		o_perr = 0; o_pder = 0; o_integ = 0; i_perr = 0; i_pder = 0; i_integ = 0;
		p_arrived = 0; p_stuck = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		send_idle_pct = 22; recv_idle_pct = 83;
		test_random(10, 50);
		send_idle_pct = 83; recv_idle_pct = 22;
		test_random(10, 50);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(12, 50);
		test_backpressure();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule
